[design/cfd_pkg.sv]
// Package with the beat types, codes and CRC helper of the frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package cfd_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;

    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam logic [7:0] TAIL_FIRST  = 8'h0D;
    localparam logic [7:0] TAIL_SECOND = 8'h0A;
    localparam logic [7:0] HDR_ID_OK   = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Byte positions within a frame, counted from the first sync byte.
    localparam logic [10:0] POS_SYNC_SECOND = 11'd1;
    localparam logic [10:0] POS_VERSION     = 11'd2;
    localparam logic [10:0] POS_TYPE        = 11'd3;
    localparam logic [10:0] POS_LEN_LOW     = 11'd5;
    localparam logic [10:0] HDR_BYTES       = 11'd10;

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    localparam logic [1:0] CFG_CHECK_MODE = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_HDR = 3'd1,
        ST_TAIL    = 3'd2,
        ST_CRC     = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_TIMEOUT = 3'd5
    } t_status;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [31:0] frame_seq;
        logic [10:0] payload_len;
        logic [31:0] valid_count;
        logic [31:0] dropped_count;
        logic [31:0] crc_error_count;
        logic [31:0] tail_error_count;
        logic [31:0] timeout_error_count;
    } t_out_item;

    typedef struct packed {
        logic       init;
        logic       update;
        logic [7:0] data;
    } t_crc_ctl;

    // CRC-16/CCITT-FALSE over one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Length field clipped to the width of the result field.
    function automatic logic [10:0] sat_len(input logic [15:0] len);
        return (|len[15:11]) ? 11'h7FF : len[10:0];
    endfunction

endpackage
`default_nettype wire

[design/cfd_crc16.sv]
// Running CRC-16/CCITT-FALSE register of the frame deframer.
`timescale 1ns / 1ps
`default_nettype none
module cfd_crc16
    import cfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_crc_ctl    i_ctl,
    output logic [15:0]      o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.update) begin
            n_crc = crc16_byte(r_crc, i_ctl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule
`default_nettype wire

[design/crc_frame_deframer.sv]
// Top level of the frame deframer: sync hunt, header capture, checks and verdicts.
//
// Usage: the input channel carries one beat per received byte or per one
// millisecond tick (op selects which). The block hunts for the A5 5A sync
// pair, captures version, type, length and sequence, forwards every payload
// byte as a result beat of kind payload, and closes each frame with exactly
// one verdict beat that holds the status, the sequence, the length and all
// five wrapping counters. Each input beat produces zero or one result beat.
// A result is in the output register the cycle after its input beat is accepted.
// Throughput is one beat per cycle unless the receiver stalls; every input
// beat is handled in a single pass of logic from the frame state registers
// to the output register. The output register decouples the two sides: a
// new beat is taken whenever the register is empty or being drained in the
// same cycle, so a stalled receiver holds the input only while a result is
// still waiting. Configuration (check mode, timeout in ticks) is to be written
// through the plain write port while the block is idle, which the block does
// not enforce; it applies to the next beat. Synchronous active-low reset returns
// to sync hunt, clears all counters and check mode, sets a 100-tick timeout.
`timescale 1ns / 1ps
`default_nettype none
module crc_frame_deframer
    import cfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic        r_check_mode;
    logic [15:0] r_timeout;

    // Frame state.
    logic [10:0] r_pos,     n_pos;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_type,    n_type;
    logic [15:0] r_length,  n_length;
    logic [31:0] r_seq,     n_seq;
    logic [15:0] r_crc_rx,  n_crc_rx;
    logic [7:0]  r_tail,    n_tail;
    logic [16:0] r_elapsed, n_elapsed;

    // Counters.
    logic [31:0] r_valid_total,   n_valid_total;
    logic [31:0] r_dropped_total, n_dropped_total;
    logic [31:0] r_crc_err_total, n_crc_err_total;
    logic [31:0] r_tail_err_total, n_tail_err_total;
    logic [31:0] r_timeout_total, n_timeout_total;

    // Output register.
    logic        r_out_valid;
    t_out_item   r_out;

    logic        in_fire;
    logic        is_tick;
    logic [7:0]  b;
    logic [16:0] elapsed_eff;
    logic        timed_out;
    logic [15:0] crc_now;
    t_crc_ctl    crc_ctl;
    logic        emit;
    logic        emit_kind;
    logic [7:0]  emit_byte;
    logic [2:0]  emit_status;
    logic [31:0] emit_seq;
    logic [15:0] emit_len;
    logic [15:0] len_new;
    logic [10:0] len_frame;
    logic [10:0] payload_end;
    logic        tail_ok;
    logic        crc_ok;
    logic        hdr_ok;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_tick    = (i_in_data.op == OP_TICK);
    assign b          = i_in_data.data_byte;

    cfd_crc16 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc_now)
    );

    // A tick advances the elapsed count before the check; a byte is checked
    // against the count as it stands.
    always_comb begin
        elapsed_eff = r_elapsed;
        if (is_tick && (r_pos >= POS_VERSION) && (r_elapsed != ELAPSED_MAX)) begin
            elapsed_eff = r_elapsed + 17'd1;
        end
        timed_out = (r_pos >= POS_VERSION) && (elapsed_eff > {1'b0, r_timeout});
    end

    // Once past the header the length field is known to lie in 1..MAX_PAYLOAD.
    assign len_frame   = r_length[10:0];
    assign payload_end = HDR_BYTES + len_frame;
    assign len_new     = {r_length[7:0], b};
    assign tail_ok     = (r_tail == TAIL_FIRST) && (b == TAIL_SECOND);
    assign crc_ok      = (r_crc_rx == crc_now);
    assign hdr_ok      = (r_version == HDR_ID_OK) && (r_type == HDR_ID_OK);

    always_comb begin
        n_pos            = r_pos;
        n_version        = r_version;
        n_type           = r_type;
        n_length         = r_length;
        n_seq            = r_seq;
        n_crc_rx         = r_crc_rx;
        n_tail           = r_tail;
        n_elapsed        = r_elapsed;
        n_valid_total    = r_valid_total;
        n_dropped_total  = r_dropped_total;
        n_crc_err_total  = r_crc_err_total;
        n_tail_err_total = r_tail_err_total;
        n_timeout_total  = r_timeout_total;
        crc_ctl          = '{init: 1'b0, update: 1'b0, data: b};
        emit             = 1'b0;
        emit_kind        = KIND_VERDICT;
        emit_byte        = 8'h00;
        emit_status      = ST_OK;
        emit_seq         = 32'h0;
        emit_len         = 16'h0;

        if (in_fire) begin
            n_elapsed = elapsed_eff;
            if (timed_out) begin
                // Drop the frame; a byte in the same beat restarts the hunt.
                n_timeout_total = r_timeout_total + 32'd1;
                n_dropped_total = r_dropped_total + 32'd1;
                emit            = 1'b1;
                emit_status     = ST_TIMEOUT;
                emit_seq        = r_seq;
                emit_len        = r_length;
                n_elapsed       = 17'h0;
                n_pos           = (!is_tick && (b == SYNC_FIRST)) ? POS_SYNC_SECOND : 11'd0;
            end else if (!is_tick) begin
                if (r_pos == 11'd0) begin
                    if (b == SYNC_FIRST) begin
                        n_pos = POS_SYNC_SECOND;
                    end
                end else if (r_pos == POS_SYNC_SECOND) begin
                    if (b == SYNC_SECOND) begin
                        n_pos     = POS_VERSION;
                        n_elapsed = 17'h0;
                        n_version = 8'h00;
                        n_type    = 8'h00;
                        n_length  = 16'h0;
                        n_seq     = 32'h0;
                        n_crc_rx  = 16'h0;
                        n_tail    = 8'h00;
                        crc_ctl.init = 1'b1;
                    end else if (b != SYNC_FIRST) begin
                        n_pos = 11'd0;
                    end
                end else begin
                    n_pos = r_pos + 11'd1;
                    if (r_pos < HDR_BYTES) begin
                        crc_ctl.update = 1'b1;
                        if (r_pos == POS_VERSION) begin
                            n_version = b;
                        end else if (r_pos == POS_TYPE) begin
                            n_type = b;
                        end else if (r_pos <= POS_LEN_LOW) begin
                            n_length = len_new;
                            if ((r_pos == POS_LEN_LOW) &&
                                ((len_new == 16'h0) || (len_new > 16'(MAX_PAYLOAD)))) begin
                                n_dropped_total = r_dropped_total + 32'd1;
                                emit            = 1'b1;
                                emit_status     = ST_LENGTH;
                                emit_len        = len_new;
                                n_pos           = 11'd0;
                                n_elapsed       = 17'h0;
                            end
                        end else begin
                            n_seq = {r_seq[23:0], b};
                        end
                    end else if (r_pos < payload_end) begin
                        crc_ctl.update = 1'b1;
                        emit           = 1'b1;
                        emit_kind      = KIND_PAYLOAD;
                        emit_byte      = b;
                    end else if (r_pos < payload_end + 11'd2) begin
                        n_crc_rx = {r_crc_rx[7:0], b};
                    end else if (r_pos == payload_end + 11'd2) begin
                        n_tail = b;
                    end else begin
                        // Last tail byte: issue the frame verdict.
                        emit      = 1'b1;
                        emit_seq  = r_seq;
                        emit_len  = r_length;
                        n_pos     = 11'd0;
                        n_elapsed = 17'h0;
                        if (r_check_mode) begin
                            if (!hdr_ok) begin
                                emit_status     = ST_BAD_HDR;
                                n_dropped_total = r_dropped_total + 32'd1;
                            end else if (!tail_ok) begin
                                emit_status      = ST_TAIL;
                                n_tail_err_total = r_tail_err_total + 32'd1;
                                n_dropped_total  = r_dropped_total + 32'd1;
                            end else if (!crc_ok) begin
                                emit_status     = ST_CRC;
                                n_crc_err_total = r_crc_err_total + 32'd1;
                                n_dropped_total = r_dropped_total + 32'd1;
                            end else begin
                                emit_status   = ST_OK;
                                n_valid_total = r_valid_total + 32'd1;
                            end
                        end else begin
                            if (tail_ok && crc_ok) begin
                                emit_status   = ST_OK;
                                n_valid_total = r_valid_total + 32'd1;
                            end else begin
                                emit_status     = tail_ok ? ST_CRC : ST_TAIL;
                                n_dropped_total = r_dropped_total + 32'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b0;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHECK_MODE: r_check_mode <= i_cfg_data[0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Frame state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos            <= 11'd0;
            r_version        <= 8'h00;
            r_type           <= 8'h00;
            r_length         <= 16'h0;
            r_seq            <= 32'h0;
            r_crc_rx         <= 16'h0;
            r_tail           <= 8'h00;
            r_elapsed        <= 17'h0;
            r_valid_total    <= 32'h0;
            r_dropped_total  <= 32'h0;
            r_crc_err_total  <= 32'h0;
            r_tail_err_total <= 32'h0;
            r_timeout_total  <= 32'h0;
        end else begin
            r_pos            <= n_pos;
            r_version        <= n_version;
            r_type           <= n_type;
            r_length         <= n_length;
            r_seq            <= n_seq;
            r_crc_rx         <= n_crc_rx;
            r_tail           <= n_tail;
            r_elapsed        <= n_elapsed;
            r_valid_total    <= n_valid_total;
            r_dropped_total  <= n_dropped_total;
            r_crc_err_total  <= n_crc_err_total;
            r_tail_err_total <= n_tail_err_total;
            r_timeout_total  <= n_timeout_total;
        end
    end

    // Output register: loaded by a beat that produces a result, emptied when
    // the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.kind                <= emit_kind;
            r_out.payload_byte        <= emit_byte;
            r_out.status              <= emit_status;
            r_out.frame_seq           <= emit_seq;
            r_out.payload_len         <= sat_len(emit_len);
            r_out.valid_count         <= n_valid_total;
            r_out.dropped_count       <= n_dropped_total;
            r_out.crc_error_count     <= n_crc_err_total;
            r_out.tail_error_count    <= n_tail_err_total;
            r_out.timeout_error_count <= n_timeout_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
